// ===== rtl/rmcl_pkg.sv =====
`timescale 1ns / 1ps

package rmcl_pkg;

  // Field widths
  localparam int WIDTH_W   = 24;
  localparam int COORD_W   = 32;
  localparam int EDGE_W    = 31;
  localparam int CELL_W    = 18;
  localparam int IDX_OUT_W = 6;
  localparam int STATUS_W  = 3;
  localparam int ACTION_W  = 2;
  localparam int AXIS_W    = 2;

  // Default table size per axis
  localparam int DEF_MAX_CELLS = 64;

  // Axis selectors
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_X_OUT = 3'd1,
    ST_Y_OUT = 3'd2,
    ST_Z_OUT = 3'd3,
    ST_EMPTY = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  // Commands from the controller to one axis lane
  typedef struct packed {
    logic clear;
    logic append;
    logic locate;
  } lane_cmd_t;

  // Status reported by one axis lane
  typedef struct packed {
    logic busy;
    logic empty;
    logic outside;
    logic full;
  } lane_stat_t;

  // One result word
  typedef struct packed {
    status_t                status;
    logic [CELL_W-1:0]      linear_cell;
    logic [IDX_OUT_W-1:0]   x_index;
    logic [IDX_OUT_W-1:0]   y_index;
    logic [IDX_OUT_W-1:0]   z_index;
  } res_t;

endpackage

// ===== rtl/rmcl_axis_lane.sv =====
`timescale 1ns / 1ps

// One axis: edge memory, cell count, last edge and a binary search engine.
module rmcl_axis_lane #(
  parameter int MAX_CELLS = rmcl_pkg::DEF_MAX_CELLS,
  localparam int CW = $clog2(MAX_CELLS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rmcl_pkg::lane_cmd_t               cmd,
  input  logic [rmcl_pkg::WIDTH_W-1:0]      width,
  input  logic [rmcl_pkg::COORD_W-1:0]      coord,
  output rmcl_pkg::lane_stat_t              stat,
  output logic [CW-1:0]                     idx,
  output logic [CW-1:0]                     count
);

  localparam int DEPTH = MAX_CELLS + 1;
  localparam int EW    = rmcl_pkg::EDGE_W;

  typedef enum logic [1:0] {
    L_IDLE   = 2'b01,
    L_SEARCH = 2'b10
  } lstate_t;

  lstate_t        state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [EW-1:0]  last_r, last_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [CW-1:0]  mid_r, mid_nxt;
  logic [EW-1:0]  coord_r, coord_nxt;
  logic           empty_r, empty_nxt;
  logic           outside_r, outside_nxt;

  logic [EW-1:0]  mem [DEPTH];
  logic [EW-1:0]  rd_data_r;
  logic [CW-1:0]  rd_addr;
  logic [CW-1:0]  wr_addr;
  logic           wr_en;

  logic           full;
  logic [EW:0]    sum;
  logic [EW-1:0]  sum_sat;
  logic           outside_now;
  logic           ge;
  logic [CW-1:0]  lo_step, hi_step;

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b} + (CW + 1)'(1);
    return s[CW:1];
  endfunction

  assign full        = (count_r == CW'(MAX_CELLS));
  assign sum         = {1'b0, last_r} + (EW + 1)'(width);
  assign sum_sat     = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
  assign outside_now = coord[rmcl_pkg::COORD_W-1] | (coord[EW-1:0] > last_r);
  assign wr_addr     = count_r + CW'(1);
  assign wr_en       = (state_r == L_IDLE) && cmd.append && !cmd.clear && !full;

  // One search step: keep the largest index whose edge is <= the point
  assign ge      = (rd_data_r <= coord_r);
  assign lo_step = ge ? mid_r : lo_r;
  assign hi_step = ge ? hi_r : (mid_r - CW'(1));

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    coord_nxt   = coord_r;
    empty_nxt   = empty_r;
    outside_nxt = outside_r;
    rd_addr     = mid_r;
    case (state_r)
      L_IDLE: begin
        if (cmd.clear) begin
          count_nxt = '0;
          last_nxt  = '0;
        end else if (cmd.append && !full) begin
          count_nxt = count_r + CW'(1);
          last_nxt  = sum_sat;
        end
        if (cmd.locate) begin
          empty_nxt   = (count_r == '0);
          outside_nxt = outside_now;
          coord_nxt   = coord[EW-1:0];
          lo_nxt      = '0;
          hi_nxt      = count_r - CW'(1);
          mid_nxt     = mid_of('0, count_r - CW'(1));
          rd_addr     = mid_nxt;
          if ((count_r > CW'(1)) && !outside_now) begin
            state_nxt = L_SEARCH;
          end
        end
      end
      L_SEARCH: begin
        lo_nxt  = lo_step;
        hi_nxt  = hi_step;
        mid_nxt = mid_of(lo_step, hi_step);
        rd_addr = mid_nxt;
        if (lo_step == hi_step) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      count_r <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    coord_r   <= coord_nxt;
    empty_r   <= empty_nxt;
    outside_r <= outside_nxt;
  end

  // Edge memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sum_sat;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign stat.busy    = (state_r == L_SEARCH);
  assign stat.empty   = empty_r;
  assign stat.outside = outside_r;
  assign stat.full    = full;
  assign idx          = lo_r;
  assign count        = count_r;

endmodule

// ===== rtl/rmcl_merge.sv =====
`timescale 1ns / 1ps

// Combines the three lane indices into the row-major cell number.
module rmcl_merge #(
  parameter int MAX_CELLS = rmcl_pkg::DEF_MAX_CELLS,
  localparam int CW = $clog2(MAX_CELLS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rmcl_pkg::status_t   status,
  input  logic [CW-1:0]       ix,
  input  logic [CW-1:0]       iy,
  input  logic [CW-1:0]       iz,
  input  logic [CW-1:0]       ny,
  input  logic [CW-1:0]       nz,
  output logic                done,
  output rmcl_pkg::res_t      res
);

  localparam int CLW = rmcl_pkg::CELL_W;
  localparam int W1  = 2 * CW + 1;
  localparam int W2  = CLW + CW + 1;

  logic              v1_r, v2_r;
  logic [CLW-1:0]    t1_r;
  rmcl_pkg::status_t st1_r;
  rmcl_pkg::res_t    res_r;
  logic [W1-1:0]     sum1;
  logic [W2-1:0]     sum2;
  logic              ok;

  // ix*ny + iy, then (..)*nz + iz, both kept modulo the cell width
  assign sum1 = W1'(ix) * W1'(ny) + W1'(iy);
  assign sum2 = W2'(t1_r) * W2'(nz) + W2'(iz);
  assign ok   = (st1_r == rmcl_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r              <= CLW'(sum1);
    st1_r             <= status;
    res_r.status      <= st1_r;
    res_r.linear_cell <= ok ? CLW'(sum2) : '0;
    res_r.x_index     <= ok ? rmcl_pkg::IDX_OUT_W'(ix) : '0;
    res_r.y_index     <= ok ? rmcl_pkg::IDX_OUT_W'(iy) : '0;
    res_r.z_index     <= ok ? rmcl_pkg::IDX_OUT_W'(iz) : '0;
  end

  assign done = v2_r;
  assign res  = res_r;

endmodule

// ===== rtl/rectilinear_mesh_cell_locate.sv =====
`timescale 1ns / 1ps
// Locate: after accept, the per-axis binary search runs, one edge memory read per step, then
// the merge stages form the cell number and the result is loaded into the output register.
// Clear and append skip search and merge. in_tready returns as the result is loaded, so a
// new word is taken only after the last one is through and the output register is free.
// Synchronous active-low reset empties all three tables and drops out_tvalid; no clearing
// pass is needed.
module rectilinear_mesh_cell_locate #(
  parameter int MAX_CELLS_PER_AXIS = rmcl_pkg::DEF_MAX_CELLS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [119:0]  in_tdata,   // width[23:0], x_coord[55:24], y_coord[87:56], z_coord[119:88]
  input  logic [3:0]    in_tuser,   // action[1:0], axis[3:2]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,  // linear_cell[17:0], x_index[23:18], y_index[29:24],
                                    // z_index[35:30], zero[39:36]
  output logic [2:0]    out_tuser   // status[2:0]
);

  localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_WAIT  = 4'b0010,
    T_MERGE = 4'b0100,
    T_OUT   = 4'b1000
  } tstate_t;

  tstate_t                 state_r, state_nxt;
  rmcl_pkg::res_t          res_r, res_nxt;
  rmcl_pkg::res_t          out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_acc;
  rmcl_pkg::action_t       act;
  logic [rmcl_pkg::AXIS_W-1:0] axis;
  rmcl_pkg::lane_cmd_t     cmd_x, cmd_y, cmd_z;
  rmcl_pkg::lane_stat_t    st_x, st_y, st_z;
  logic [CW-1:0]           idx_x, idx_y, idx_z;
  logic [CW-1:0]           cnt_x, cnt_y, cnt_z;
  logic                    merge_start, merge_done;
  rmcl_pkg::res_t          merge_res;
  rmcl_pkg::status_t       loc_status;
  logic                    app_full;

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign act       = rmcl_pkg::action_t'(in_tuser[1:0]);
  assign axis      = in_tuser[3:2];

  // Lane commands
  always_comb begin
    cmd_x.clear  = in_acc && (act == rmcl_pkg::ACT_CLEAR);
    cmd_x.append = in_acc && (act == rmcl_pkg::ACT_APPEND) && (axis == rmcl_pkg::AXIS_X);
    cmd_x.locate = in_acc && (act == rmcl_pkg::ACT_LOCATE);
    cmd_y.clear  = cmd_x.clear;
    cmd_y.append = in_acc && (act == rmcl_pkg::ACT_APPEND) && (axis == rmcl_pkg::AXIS_Y);
    cmd_y.locate = cmd_x.locate;
    cmd_z.clear  = cmd_x.clear;
    cmd_z.append = in_acc && (act == rmcl_pkg::ACT_APPEND) && (axis == rmcl_pkg::AXIS_Z);
    cmd_z.locate = cmd_x.locate;
  end

  rmcl_axis_lane #(.MAX_CELLS(MAX_CELLS_PER_AXIS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_x), .width(in_tdata[23:0]),
    .coord(in_tdata[55:24]), .stat(st_x), .idx(idx_x), .count(cnt_x)
  );

  rmcl_axis_lane #(.MAX_CELLS(MAX_CELLS_PER_AXIS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_y), .width(in_tdata[23:0]),
    .coord(in_tdata[87:56]), .stat(st_y), .idx(idx_y), .count(cnt_y)
  );

  rmcl_axis_lane #(.MAX_CELLS(MAX_CELLS_PER_AXIS)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_z), .width(in_tdata[23:0]),
    .coord(in_tdata[119:88]), .stat(st_z), .idx(idx_z), .count(cnt_z)
  );

  // Locate status: empty axis first, then x, y, z range
  always_comb begin
    if (st_x.empty || st_y.empty || st_z.empty) begin
      loc_status = rmcl_pkg::ST_EMPTY;
    end else if (st_x.outside) begin
      loc_status = rmcl_pkg::ST_X_OUT;
    end else if (st_y.outside) begin
      loc_status = rmcl_pkg::ST_Y_OUT;
    end else if (st_z.outside) begin
      loc_status = rmcl_pkg::ST_Z_OUT;
    end else begin
      loc_status = rmcl_pkg::ST_OK;
    end
  end

  rmcl_merge #(.MAX_CELLS(MAX_CELLS_PER_AXIS)) u_merge (
    .clk(clk), .rst_n(rst_n), .start(merge_start), .status(loc_status),
    .ix(idx_x), .iy(idx_y), .iz(idx_z), .ny(cnt_y), .nz(cnt_z),
    .done(merge_done), .res(merge_res)
  );

  // Full check for the selected append axis
  always_comb begin
    case (axis)
      rmcl_pkg::AXIS_X: app_full = st_x.full;
      rmcl_pkg::AXIS_Y: app_full = st_y.full;
      rmcl_pkg::AXIS_Z: app_full = st_z.full;
      default:          app_full = 1'b0;
    endcase
  end

  // Controller
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    merge_start   = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          res_nxt.status      = rmcl_pkg::ST_OK;
          res_nxt.linear_cell = '0;
          res_nxt.x_index     = '0;
          res_nxt.y_index     = '0;
          res_nxt.z_index     = '0;
          if (act == rmcl_pkg::ACT_LOCATE) begin
            state_nxt = T_WAIT;
          end else begin
            if ((act == rmcl_pkg::ACT_APPEND) && app_full) begin
              res_nxt.status = rmcl_pkg::ST_FULL;
            end
            state_nxt = T_OUT;
          end
        end
      end
      T_WAIT: begin
        if (!st_x.busy && !st_y.busy && !st_z.busy) begin
          merge_start = 1'b1;
          state_nxt   = T_MERGE;
        end
      end
      T_MERGE: begin
        if (merge_done) begin
          res_nxt   = merge_res;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.z_index, out_r.y_index, out_r.x_index,
                       out_r.linear_cell};
  assign out_tuser  = out_r.status;

endmodule

// ===== test/tb_rectilinear_mesh_cell_locate.sv =====
`timescale 1ns / 1ps

module tb_rectilinear_mesh_cell_locate;
  import rmcl_pkg::*;

  localparam int                MAX_CELLS  = DEF_MAX_CELLS;
  localparam logic [AXIS_W-1:0] AXIS_NONE  = 2'd3;      // not an axis; append is ignored
  localparam logic [31:0]       Q_ONE      = 32'h0001_0000;
  localparam logic [30:0]       EDGE_LIMIT = 31'h7FFF_FFFF;

  // Expected-result tracker: keeps its own edge tables and predicts each word
  class mesh_scoreboard;
    logic [EDGE_W-1:0] edge_tab [3][MAX_CELLS+1];
    int unsigned       cell_cnt [3];
    res_t              expected_q [$];
    int                fails;

    function new();
      foreach (edge_tab[a, k]) edge_tab[a][k] = '0;
      foreach (cell_cnt[a]) cell_cnt[a] = 0;
      fails = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Cell index along one axis: last cell whose lower edge <= p, last edge -> last cell
    function bit find_cell(int a, logic signed [31:0] p, output int unsigned idx);
      longint      pv;
      longint      ek;
      longint      last_e;
      int unsigned n;
      int unsigned le;
      pv = p;
      n = cell_cnt[a];
      ek = edge_tab[a][0];
      last_e = edge_tab[a][n];
      idx = 0;
      if (pv < ek || pv > last_e) return 1'b0;
      if (pv == last_e) begin
        idx = n - 1;
        return 1'b1;
      end
      le = 0;
      for (int k = 0; k <= n; k++) begin
        ek = edge_tab[a][k];
        if (ek <= pv) le++;
      end
      idx = le - 1;
      return 1'b1;
    endfunction

    // Called for every accepted input word
    function void note_word(action_t act, logic [AXIS_W-1:0] axis, logic [WIDTH_W-1:0] w,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      res_t        r;
      status_t     st;
      int unsigned ix, iy, iz, lin, n;
      longint      sum;
      st = ST_OK;
      ix = 0;
      iy = 0;
      iz = 0;
      lin = 0;
      case (act)
        ACT_CLEAR: begin
          foreach (cell_cnt[a]) begin
            cell_cnt[a] = 0;
            edge_tab[a][0] = '0;
          end
        end
        ACT_APPEND: begin
          if (axis <= AXIS_Z) begin
            n = cell_cnt[axis];
            if (n >= MAX_CELLS) begin
              st = ST_FULL;
            end else begin
              sum = longint'(edge_tab[axis][n]) + longint'(w);
              if (sum > longint'(EDGE_LIMIT)) sum = EDGE_LIMIT;
              edge_tab[axis][n+1] = sum[EDGE_W-1:0];
              cell_cnt[axis] = n + 1;
            end
          end
        end
        ACT_LOCATE: begin
          if (cell_cnt[0] == 0 || cell_cnt[1] == 0 || cell_cnt[2] == 0) st = ST_EMPTY;
          else if (!find_cell(0, px, ix)) st = ST_X_OUT;
          else if (!find_cell(1, py, iy)) st = ST_Y_OUT;
          else if (!find_cell(2, pz, iz)) st = ST_Z_OUT;
          if (st != ST_OK) begin
            ix = 0;
            iy = 0;
            iz = 0;
          end else begin
            lin = (ix * cell_cnt[1] + iy) * cell_cnt[2] + iz;
          end
        end
        default: ;
      endcase
      r.status      = st;
      r.linear_cell = lin[CELL_W-1:0];
      r.x_index     = ix[IDX_OUT_W-1:0];
      r.y_index     = iy[IDX_OUT_W-1:0];
      r.z_index     = iz[IDX_OUT_W-1:0];
      expected_q = {expected_q, r};
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        fails++;
      end
    endfunction

    // Called for every accepted result word
    function void check_word(logic [39:0] data, logic [2:0] user);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: tdata %h tuser %h", data, user);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("status", e.status, user);
      cmp_field("linear_cell", e.linear_cell, data[17:0]);
      cmp_field("x_index", e.x_index, data[23:18]);
      cmp_field("y_index", e.y_index, data[29:24]);
      cmp_field("z_index", e.z_index, data[35:30]);
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata   = '0;   // width[23:0], x_coord[55:24], y_coord[87:56], z_coord[119:88]
  logic [3:0]   in_tuser   = '0;   // action[1:0], axis[3:2]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;         // linear_cell[17:0], x_index[23:18], y_index[29:24],
                                   // z_index[35:30], zero[39:36]
  logic [2:0]   out_tuser;         // status[2:0]

  mesh_scoreboard board = new();
  int unsigned    snd_idle_pct = 0;
  int unsigned    rcv_idle_pct = 0;
  int unsigned    words_sent   = 0;

  rectilinear_mesh_cell_locate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random backpressure, check on handshake
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata, out_tuser);
  end

  // Send one word; entered and left at a falling edge
  task automatic send_word(action_t act, logic [AXIS_W-1:0] axis, logic [WIDTH_W-1:0] w,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {axis, act};
    in_tdata  <= {pz, py, px, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_word(act, axis, w, px, py, pz);
    if (act != ACT_NONE && !(act == ACT_APPEND && axis > AXIS_Z)) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_append(logic [AXIS_W-1:0] axis, logic [WIDTH_W-1:0] w);
    send_word(ACT_APPEND, axis, w, $urandom, $urandom, $urandom);
  endtask

  task automatic send_locate(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(ACT_LOCATE, 2'($urandom), 24'($urandom), px, py, pz);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [WIDTH_W-1:0] pick_width();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(1, 32'h4_0000));
    endcase
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r <= 2) return MAX_CELLS;
    if (r <= 4) return $urandom_range(9, MAX_CELLS - 1);
    return $urandom_range(1, 8);
  endfunction

  // Coordinate near the interesting spots of one axis
  function automatic logic [31:0] pick_coord(int a);
    int unsigned n;
    int unsigned k;
    longint      lo;
    longint      hi;
    n = board.cell_cnt[a];
    if (n == 0) return $urandom;
    case ($urandom_range(9))
      0: return 32'(board.edge_tab[a][$urandom_range(n)]);
      1: return 32'(board.edge_tab[a][n]);
      2: return ($urandom_range(1) != 0) ? 32'(0) - $urandom_range(1, 32'h2_0000)
                                         : {1'b1, 31'($urandom)};
      3: return 32'(board.edge_tab[a][n]) + $urandom_range(1, 32'h2_0000);
      4: return $urandom;
      default: begin
        k = $urandom_range(n - 1);
        lo = board.edge_tab[a][k];
        hi = board.edge_tab[a][k+1];
        if (hi > lo) return 32'(lo + $urandom_range(32'(hi - lo - 1)));
        return 32'(lo);
      end
    endcase
  endfunction

  // Clear, then build all three tables; full axes sometimes get extra appends
  task automatic build_mesh(int unsigned nx, int unsigned ny, int unsigned nz);
    int unsigned cnt [3];
    cnt = '{nx, ny, nz};
    send_word(ACT_CLEAR, 2'($urandom), 24'($urandom), $urandom, $urandom, $urandom);
    for (int a = 0; a < 3; a++) begin
      repeat (cnt[a]) send_append(2'(a), pick_width());
      if (cnt[a] == MAX_CELLS && $urandom_range(1) != 0)
        repeat ($urandom_range(1, 2)) send_append(2'(a), pick_width());
    end
  endtask

  task automatic run_phase(int unsigned target, bit start_full);
    int unsigned seq;
    seq = 0;
    while (words_sent < target) begin
      if (!(start_full && seq == 0) && $urandom_range(99) < 15) begin
        // noise: any action, any axis, raw fields
        repeat ($urandom_range(1, 6))
          send_word(action_t'($urandom_range(3)), 2'($urandom), 24'($urandom),
                    $urandom, $urandom, $urandom);
      end else begin
        if (start_full && seq == 0) build_mesh(MAX_CELLS, MAX_CELLS, MAX_CELLS);
        else build_mesh(pick_count(), pick_count(), pick_count());
        repeat ($urandom_range(8, 30)) send_locate(pick_coord(0), pick_coord(1), pick_coord(2));
      end
      seq++;
    end
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tables, ignored words, zero and max widths, edges, range order
    send_locate('0, '0, '0);
    send_word(ACT_NONE, AXIS_NONE, 24'hFF_FFFF, '1, '1, '1);
    send_append(AXIS_NONE, 24'h01_0000);
    send_append(AXIS_X, 24'h01_0000);
    send_append(AXIS_X, 24'h00_0000);
    send_append(AXIS_X, 24'hFF_FFFF);
    send_locate('0, '0, '0);
    send_append(AXIS_Y, 24'h00_8000);
    send_append(AXIS_Y, 24'h00_8000);
    send_append(AXIS_Z, 24'h02_0000);
    send_locate('0, '0, '0);
    send_locate(Q_ONE, 32'h0000_8000, Q_ONE);
    send_locate(Q_ONE + 32'h00FF_FFFF, Q_ONE, 2 * Q_ONE);
    send_locate(32'hFFFF_FFFF, '0, '0);
    send_locate(32'h8000_0000, '0, '0);
    send_locate(32'h7FFF_FFFF, '0, '0);
    send_locate('0, Q_ONE + 1, '0);
    send_locate('0, '0, 2 * Q_ONE + 1);
    send_locate(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_locate('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_append(AXIS_Z, 24'h00_0000);
    send_locate(Q_ONE, Q_ONE, 2 * Q_ONE);
    send_word(ACT_CLEAR, AXIS_Z, 24'hFF_FFFF, '1, '1, '1);
    send_locate('0, '0, '0);

    // Random: three backpressure profiles, sender drains between them
    snd_idle_pct = 24;
    rcv_idle_pct = 52;
    run_phase(350, 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    snd_idle_pct = 52;
    rcv_idle_pct = 24;
    run_phase(700, 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(1050, 1'b1);
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rmcl_pkg.sv
rtl/rmcl_axis_lane.sv
rtl/rmcl_merge.sv
rtl/rectilinear_mesh_cell_locate.sv
test/tb_rectilinear_mesh_cell_locate.sv
